// ----- sv/bsr_pkg.sv -----
package bsr_pkg;

  // Fixed-point format and round count
  localparam int FRAC_BITS  = 16;
  localparam int ITERATIONS = 34;

  // Port widths
  localparam int VALUE_W = 32;
  localparam int ROOT_W  = 24;

  // Internal widths: a non-negative value fits in VALUE_W-1 bits, and so do both bounds
  localparam int BOUND_W = VALUE_W - 1;
  localparam int PROD_W  = 2 * BOUND_W;
  localparam int TGT_W   = BOUND_W + FRAC_BITS;
  localparam int CNT_W   = $clog2(ITERATIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_CMP,
    ST_DONE
  } bsr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mult;
    logic update;
  } bsr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic neg;
  } bsr_status_t;

endpackage

// ----- sv/bsr_datapath.sv -----
module bsr_datapath
  import bsr_pkg::*;
(
  input  logic                      clk,
  input  bsr_cmd_t                  cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output bsr_status_t               status,
  output logic        [ROOT_W-1:0]  root,
  output logic                      negative_error
);

  localparam logic [BOUND_W-1:0] ONE = BOUND_W'(1) << FRAC_BITS;

  logic [BOUND_W-1:0] lo_r, hi_r, mid_r;
  logic [TGT_W-1:0]   target_r;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;

  logic [BOUND_W-1:0] v;
  logic [BOUND_W:0]   sum;
  logic [BOUND_W-1:0] mid;

  assign v   = in_value[BOUND_W-1:0];
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[BOUND_W:1];

  // Bound, midpoint and square registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r    <= in_value[VALUE_W-1];
      target_r <= {v, {FRAC_BITS{1'b0}}};
      if (v < ONE) begin
        lo_r <= v;
        hi_r <= ONE;
      end else begin
        lo_r <= ONE;
        hi_r <= v;
      end
    end
    if (cmd.mult) begin
      mid_r  <= mid;
      prod_r <= {{BOUND_W{1'b0}}, mid} * {{BOUND_W{1'b0}}, mid};
    end
    if (cmd.update) begin
      if (prod_r > PROD_W'(target_r)) begin
        hi_r <= mid_r;
      end else begin
        lo_r <= mid_r;
      end
    end
  end

  assign status.neg     = neg_r;
  assign root           = neg_r ? '0 : mid[ROOT_W-1:0];
  assign negative_error = neg_r;

endmodule

// ----- sv/bsr_ctrl.sv -----
module bsr_ctrl
  import bsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  bsr_status_t status,
  output bsr_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  bsr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and round counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    busy       = 1'b1;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        // negative operand skips the search
        if (status.neg) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mult  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.update = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ITERATIONS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MULT;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/bisection_square_root_core.sv -----
// Square root by bisection, signed Q16.16 in, unsigned Q8.16 out.
// Runs ITERATIONS bisection rounds (34); each round is a squaring step (ST_MULT) followed by a
// compare/update step (ST_CMP), and the result strobes from ST_DONE. A new operand is taken
// only after that strobe, once back in idle; busy is high from the transfer until idle.
// A negative operand skips the search: ST_MULT goes straight to ST_DONE, which strobes the result.
// Synchronous active-low reset returns the controller to idle; the receiver cannot stall.
module bisection_square_root_core
  import bsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  output logic        [ROOT_W-1:0]  out_root,
  output logic                      out_negative_error
);

  bsr_cmd_t    cmd;
  bsr_status_t status;

  // Sequencer
  bsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Bounds, squaring and compare
  bsr_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .in_value       (in_value),
    .status         (status),
    .root           (out_root),
    .negative_error (out_negative_error)
  );

endmodule
